>>> rtl/assert_macros.svh
// Assertion macros used by the scan state module of the victim selector.
// Depends on nothing; every use names its own clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CVS_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("victim selector assertion failed");

// A condition at one edge that implies another at the next edge.
`define CVS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("victim selector assertion failed");

`endif

>>> rtl/cvs_pkg.sv
// Types, codes and constants of the compaction victim selector.
// Used by the interface users, the pipeline modules and the top level.
`default_nettype none

package cvs_pkg;

  localparam int unsigned MAX_DATAFILES = 65536;
  localparam logic [47:0] BUDGET_FLOOR = 48'h80_0000;
  localparam logic [48:0] BUDGET_MAX = {49{1'b1}};
  localparam logic [10:0] COUNT_MAX = {11{1'b1}};

  typedef enum logic [2:0] {
    V_SKIP        = 3'd0,
    V_SELECT      = 3'd1,
    V_SELECT_STOP = 3'd2,
    V_STOP_BEFORE = 3'd3,
    V_BLOCKED     = 3'd4,
    V_IGNORED     = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    R_NONE      = 3'd0,
    R_SMALL     = 3'd1,
    R_EMPTY     = 3'd2,
    R_ONLYDEL   = 3'd3,
    R_DEADBYTES = 3'd4,
    R_DEADSHARE = 3'd5,
    R_DEADCOUNT = 3'd6
  } reason_t;

  typedef enum logic [2:0] {
    CFG_SMALL_FILE_SIZE  = 3'd0,
    CFG_DEAD_BYTES_LIMIT = 3'd1,
    CFG_DEAD_SHARE_Q16   = 3'd2,
    CFG_DEAD_COUNT_LIMIT = 3'd3,
    CFG_MAX_FILES        = 3'd4,
    CFG_SIZE_FACTOR      = 3'd5,
    CFG_JOURNAL_BYTES    = 3'd6,
    CFG_MAX_RESULT_BYTES = 3'd7
  } cfg_index_t;

  typedef logic [47:0] cfg_data_t;

  typedef struct packed {
    logic [31:0] small_file_size;
    logic [47:0] dead_bytes_limit;
    logic [16:0] dead_share_q16;
    logic [31:0] dead_count_limit;
    logic [10:0] max_files;
    logic [7:0]  size_factor;
    logic [31:0] journal_bytes;
    logic [47:0] max_result_bytes;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    small_file_size:  32'd0,
    dead_bytes_limit: 48'd0,
    dead_share_q16:   17'd32768,
    dead_count_limit: 32'd0,
    max_files:        11'd3,
    size_factor:      8'd3,
    journal_bytes:    32'd33554432,
    max_result_bytes: 48'd134217728
  };

  typedef struct packed {
    logic        scan_first;
    logic        last_file;
    logic [15:0] file_index;
    logic        collection_empty;
    logic        resumed;
    logic [31:0] file_capacity;
    logic        has_uncollected;
    logic [31:0] alive_count;
    logic [31:0] dead_count;
    logic [31:0] deletion_count;
    logic [47:0] dead_bytes;
    logic [47:0] alive_bytes;
  } record_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [2:0]  reason_code;
    logic        keep_deletions;
    logic [16:0] resume_index;
    logic [10:0] selected_total;
  } result_t;

  // Rule outcomes of one record that do not depend on the scan state.
  typedef struct packed {
    logic        first;
    logic        resumed;
    logic        coll_empty;
    logic        uncollected;
    logic        small_hit;
    logic        empty_hit;
    logic        onlydel_hit;
    logic        dbytes_hit;
    logic        share_hit;
    logic        dcount_hit;
    logic        alive_nz;
    logic        idx_nz;
    logic [31:0] cap;
    logic [16:0] resume_val;
  } flags_t;

endpackage

`default_nettype wire

>>> rtl/cvs_stream_if.sv
// Valid/ready channel that carries one item of payload type T.
// Depends on nothing; the payload type is given where it is instantiated.
`default_nettype none

interface cvs_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/cvs_budget.sv
// Byte budget register: size factor times journal size, clamped.
// Depends on cvs_pkg.
`default_nettype none

module cvs_budget (
  input  wire logic          clk,
  input  wire cvs_pkg::cfg_t cfg,
  output logic [47:0]        limit
);
  import cvs_pkg::*;

  logic [39:0] product;
  logic [47:0] limit_next;

  assign product = cfg.size_factor * cfg.journal_bytes;

  always_comb begin
    limit_next = {8'd0, product};
    if (limit_next < BUDGET_FLOOR) begin
      limit_next = BUDGET_FLOOR;
    end
    if (limit_next >= cfg.max_result_bytes) begin
      limit_next = cfg.max_result_bytes;
    end
  end

  always_ff @(posedge clk) begin
    limit <= limit_next;
  end

endmodule

`default_nettype wire

>>> rtl/cvs_rule_decode.sv
// Input register and two stages that evaluate the state-free rules of a record.
// Depends on cvs_pkg and cvs_stream_if.
`default_nettype none

module cvs_rule_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire cvs_pkg::cfg_t   cfg,
  cvs_stream_if.sink           records,
  output logic                 flags_valid,
  output cvs_pkg::flags_t      flags
);
  import cvs_pkg::*;

  logic        v1;
  logic        v2;
  record_t     r1;
  flags_t      s2;
  logic [65:0] prod_total;
  logic [48:0] prod_cap;
  logic [47:0] dead_q;
  logic        dead_nz;

  flags_t      s2_next;
  logic [48:0] dead_sum;
  logic [65:0] prod_total_next;
  logic [48:0] prod_cap_next;
  logic [16:0] idx_p1;
  logic [65:0] dead_scaled;
  flags_t      flags_next;

  assign records.ready = adv;

  always_comb begin
    dead_sum        = {1'b0, r1.dead_bytes} + {1'b0, r1.alive_bytes};
    prod_total_next = r1.dead_bytes == 48'd0 ? 66'd0 : cfg.dead_share_q16 * dead_sum;
    prod_cap_next   = cfg.dead_share_q16 * r1.file_capacity;
    idx_p1          = {1'b0, r1.file_index} + 17'd1;

    s2_next             = '0;
    s2_next.first       = r1.scan_first;
    s2_next.resumed     = r1.resumed;
    s2_next.coll_empty  = r1.collection_empty;
    s2_next.uncollected = r1.has_uncollected;
    s2_next.small_hit   = (r1.file_capacity < cfg.small_file_size) && !r1.last_file;
    s2_next.empty_hit   = r1.collection_empty &&
                          ((r1.alive_count != 32'd0) || (r1.dead_count != 32'd0) ||
                           (r1.deletion_count != 32'd0));
    s2_next.onlydel_hit = (r1.alive_count == 32'd0) && (r1.deletion_count != 32'd0);
    s2_next.dbytes_hit  = r1.dead_bytes >= cfg.dead_bytes_limit;
    s2_next.dcount_hit  = r1.dead_count >= cfg.dead_count_limit;
    s2_next.alive_nz    = r1.alive_count != 32'd0;
    s2_next.idx_nz      = r1.file_index != 16'd0;
    s2_next.cap         = r1.file_capacity;
    if (32'(idx_p1) > MAX_DATAFILES) begin
      s2_next.resume_val = 17'(MAX_DATAFILES);
    end else begin
      s2_next.resume_val = idx_p1;
    end
  end

  always_comb begin
    dead_scaled          = {2'b00, dead_q, 16'd0};
    flags_next           = s2;
    flags_next.share_hit = dead_nz &&
                           ((dead_scaled >= prod_total) ||
                            (dead_scaled >= {17'd0, prod_cap}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      flags_valid <= 1'b0;
    end else if (adv) begin
      v1          <= records.valid;
      v2          <= v1;
      flags_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1         <= records.data;
      s2         <= s2_next;
      prod_total <= prod_total_next;
      prod_cap   <= prod_cap_next;
      dead_q     <= r1.dead_bytes;
      dead_nz    <= r1.dead_bytes != 48'd0;
      flags      <= flags_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/cvs_scan_state.sv
// Scan state and result register: applies the rule order, budget and count limits.
// Depends on cvs_pkg, cvs_stream_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cvs_scan_state (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cvs_pkg::cfg_t   cfg,
  input  wire logic [47:0]     limit,
  input  wire logic            flags_valid,
  input  wire cvs_pkg::flags_t flags,
  output logic                 adv,
  cvs_stream_if.source         verdicts
);
  import cvs_pkg::*;

  logic        scan_stopped;
  logic        compact_sticky;
  reason_t     current_reason;
  logic        alive_seen;
  logic [48:0] budget_used;
  logic [10:0] chosen_count;
  logic [16:0] resume_reg;

  logic        scan_stopped_next;
  logic        compact_sticky_next;
  reason_t     current_reason_next;
  logic        alive_seen_next;
  logic [48:0] budget_used_next;
  logic [10:0] chosen_count_next;
  logic [16:0] resume_reg_next;
  result_t     result_next;

  logic        fire;
  logic [49:0] sum;
  logic        sum_ge_limit;
  logic        sum_ge_small;
  logic [10:0] count_inc;
  verdict_t    verdict;
  logic        keep;

  assign adv  = !verdicts.valid || verdicts.ready;
  assign fire = flags_valid && adv;

  always_comb begin
    scan_stopped_next   = scan_stopped;
    compact_sticky_next = compact_sticky;
    current_reason_next = current_reason;
    alive_seen_next     = alive_seen;
    budget_used_next    = budget_used;
    chosen_count_next   = chosen_count;
    resume_reg_next     = resume_reg;
    keep                = 1'b0;

    if (flags.first) begin
      scan_stopped_next   = 1'b0;
      compact_sticky_next = 1'b0;
      current_reason_next = R_NONE;
      budget_used_next    = '0;
      chosen_count_next   = '0;
      resume_reg_next     = '0;
      alive_seen_next     = flags.resumed && !flags.coll_empty;
    end

    sum          = {1'b0, budget_used_next} + {18'd0, flags.cap};
    sum_ge_limit = sum >= {2'b00, limit};
    sum_ge_small = sum >= {18'd0, cfg.small_file_size};
    count_inc    = (chosen_count_next == COUNT_MAX) ? chosen_count_next
                                                    : chosen_count_next + 11'd1;

    if (scan_stopped_next) begin
      verdict = V_IGNORED;
    end else if (flags.uncollected) begin
      verdict           = V_BLOCKED;
      resume_reg_next   = flags.resume_val;
      scan_stopped_next = 1'b1;
    end else begin
      if (!compact_sticky_next && flags.small_hit) begin
        compact_sticky_next = 1'b1;
        current_reason_next = R_SMALL;
      end else if (flags.empty_hit) begin
        compact_sticky_next = 1'b1;
        current_reason_next = R_EMPTY;
      end else if (!alive_seen_next && flags.onlydel_hit) begin
        compact_sticky_next = 1'b1;
        current_reason_next = R_ONLYDEL;
      end else if (flags.dbytes_hit) begin
        compact_sticky_next = 1'b1;
        current_reason_next = R_DEADBYTES;
      end else if (flags.share_hit) begin
        compact_sticky_next = 1'b1;
        current_reason_next = R_DEADSHARE;
      end else if (flags.dcount_hit) begin
        compact_sticky_next = 1'b1;
        current_reason_next = R_DEADCOUNT;
      end

      if (!compact_sticky_next) begin
        verdict = V_SKIP;
        if (flags.alive_nz) begin
          alive_seen_next = 1'b1;
        end
      end else begin
        resume_reg_next = flags.resume_val;
        if ((current_reason_next != R_ONLYDEL) && (chosen_count_next != 11'd0) &&
            sum_ge_limit &&
            ((chosen_count_next != 11'd1) || (current_reason_next != R_SMALL))) begin
          verdict           = V_STOP_BEFORE;
          scan_stopped_next = 1'b1;
        end else begin
          budget_used_next  = sum[49] ? BUDGET_MAX : sum[48:0];
          keep              = alive_seen_next && flags.idx_nz;
          chosen_count_next = count_inc;
          if (sum_ge_limit || (sum_ge_small && (count_inc >= cfg.max_files))) begin
            verdict           = V_SELECT_STOP;
            scan_stopped_next = 1'b1;
          end else begin
            verdict = V_SELECT;
            if (flags.alive_nz) begin
              alive_seen_next = 1'b1;
            end
          end
        end
      end
    end

    result_next.verdict        = verdict;
    result_next.reason_code    = current_reason_next;
    result_next.keep_deletions = keep;
    result_next.resume_index   = (chosen_count_next != 11'd0) ? resume_reg_next : 17'd0;
    result_next.selected_total = chosen_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_stopped   <= 1'b0;
      compact_sticky <= 1'b0;
      current_reason <= R_NONE;
      alive_seen     <= 1'b0;
      budget_used    <= '0;
      chosen_count   <= '0;
      resume_reg     <= '0;
      verdicts.valid <= 1'b0;
    end else begin
      if (adv) begin
        verdicts.valid <= flags_valid;
      end
      if (fire) begin
        scan_stopped   <= scan_stopped_next;
        compact_sticky <= compact_sticky_next;
        current_reason <= current_reason_next;
        alive_seen     <= alive_seen_next;
        budget_used    <= budget_used_next;
        chosen_count   <= chosen_count_next;
        resume_reg     <= resume_reg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      verdicts.data <= result_next;
    end
  end

  `CVS_ASSERT_NEXT(a_stopped_ignored, clk, rst,
    fire && scan_stopped && !flags.first, verdicts.data.verdict == V_IGNORED)
  `CVS_ASSERT_NEXT(a_count_step, clk, rst, fire && !flags.first,
    (chosen_count == $past(chosen_count)) || (chosen_count == $past(chosen_count) + 11'd1))
  `CVS_ASSERT_NEXT(a_budget_grows, clk, rst, fire && !flags.first,
    budget_used >= $past(budget_used))
  `CVS_ASSERT(a_keep_on_select, clk, rst,
    !(verdicts.valid && verdicts.data.keep_deletions) ||
    (verdicts.data.verdict == V_SELECT) || (verdicts.data.verdict == V_SELECT_STOP))

endmodule

`default_nettype wire

>>> rtl/compaction_victim_selector.sv
// Path: an accepted record passes the input register, the decode stages and the
// result register. Throughput: one record per cycle; the scan state update is a loop
// in the last stage, and a stalled result holds every stage in place.
// Reset: rst is synchronous and clears the stage valids, the scan state and the
// configuration registers to their defaults; there is no clearing pass.
`default_nettype none

module compaction_victim_selector (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire cvs_pkg::cfg_index_t cfg_index,
  input  wire cvs_pkg::cfg_data_t  cfg_data,
  cvs_stream_if.sink               records,
  cvs_stream_if.source             verdicts
);
  import cvs_pkg::*;

  cfg_t        cfg;
  logic [47:0] limit;
  logic        adv;
  logic        flags_valid;
  flags_t      flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_SMALL_FILE_SIZE:  cfg.small_file_size  <= cfg_data[31:0];
        CFG_DEAD_BYTES_LIMIT: cfg.dead_bytes_limit <= cfg_data;
        CFG_DEAD_SHARE_Q16:   cfg.dead_share_q16   <= cfg_data[16:0];
        CFG_DEAD_COUNT_LIMIT: cfg.dead_count_limit <= cfg_data[31:0];
        CFG_MAX_FILES:        cfg.max_files        <= cfg_data[10:0];
        CFG_SIZE_FACTOR:      cfg.size_factor      <= cfg_data[7:0];
        CFG_JOURNAL_BYTES:    cfg.journal_bytes    <= cfg_data[31:0];
        CFG_MAX_RESULT_BYTES: cfg.max_result_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cvs_budget u_budget (
    .clk   (clk),
    .cfg   (cfg),
    .limit (limit)
  );

  cvs_rule_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .cfg         (cfg),
    .records     (records),
    .flags_valid (flags_valid),
    .flags       (flags)
  );

  cvs_scan_state u_state (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .limit       (limit),
    .flags_valid (flags_valid),
    .flags       (flags),
    .adv         (adv),
    .verdicts    (verdicts)
  );

endmodule

`default_nettype wire

>>> tb/sv/compaction_victim_selector_tb.sv
// Self-checking testbench for the compaction victim selector: a bursty record driver,
// a stalling verdict monitor and a scan-state predictor that forecasts every verdict.
// Depends on cvs_pkg, cvs_stream_if and compaction_victim_selector from the RTL.
module compaction_victim_selector_tb;
  import cvs_pkg::*;

  localparam int CYCLE_LIMIT = 40000;
  localparam int PHASE_RECORDS = 135;
  localparam int LONG_SCAN = 300;
  localparam int IDLE_SETTLE = 6;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_CHOKED} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  cfg_index_t cfg_index = CFG_SMALL_FILE_SIZE;
  cfg_data_t cfg_data = '0;

  cvs_stream_if #(.T(record_t)) record_ch ();
  cvs_stream_if #(.T(result_t)) result_ch ();

  compaction_victim_selector u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .records  (record_ch.sink),
    .verdicts (result_ch.source)
  );

  record_t record_queue[$];
  result_t expected_results[$];

  cfg_t shadow_cfg = CFG_RESET;
  logic scan_halted = 1'b0;
  logic merge_sticky = 1'b0;
  reason_t held_reason = R_NONE;
  logic live_seen = 1'b0;
  logic [48:0] bytes_taken = '0;
  logic [10:0] files_taken = '0;
  logic [16:0] next_start = '0;

  int error_count = 0;
  int records_sent = 0;
  int results_checked = 0;
  int config_sets = 0;
  int cycle_count = 0;
  int verdict_seen [0:7];
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  rx_mode_t stall_mode = RX_OPEN;

  cfg_data_t reg_lo [8] = '{48'd0, 48'd0, 48'd0, 48'd0, 48'd1, 48'd0, 48'd0, 48'd0};
  cfg_data_t reg_hi [8] = '{48'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd65536, 48'hFFFF_FFFF,
                            48'd1024, 48'd255, 48'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF};

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles.", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic note_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) $display("[%0t] result %0d: %s", $time, results_checked, msg);
  endtask

  function automatic logic [63:0] rand_mag(int unsigned w);
    logic [63:0] v;
    int unsigned len;
    len = $urandom_range(0, w);
    v = {$urandom, $urandom};
    if (len == 0) return 64'd0;
    return v & ((64'd1 << len) - 64'd1);
  endfunction

  // True when part / whole reaches q16 / 65536, with no rounding.
  function automatic bit share_met(logic [47:0] part, logic [48:0] whole, logic [16:0] q16);
    logic [79:0] lhs;
    logic [79:0] rhs;
    lhs = 80'(part) << 16;
    rhs = 80'(q16) * 80'(whole);
    return lhs >= rhs;
  endfunction

  function automatic result_t judge_record(record_t r);
    result_t res;
    verdict_t v;
    reason_t hit;
    logic [63:0] budget;
    logic [49:0] bytes_after;
    logic [16:0] idx_next;
    logic keep;
    keep = 1'b0;
    hit = R_NONE;
    idx_next = {1'b0, r.file_index} + 17'd1;
    if (idx_next > MAX_DATAFILES) idx_next = 17'(MAX_DATAFILES);
    budget = 64'(shadow_cfg.size_factor) * 64'(shadow_cfg.journal_bytes);
    if (budget < 64'(BUDGET_FLOOR)) budget = 64'(BUDGET_FLOOR);
    if (budget >= 64'(shadow_cfg.max_result_bytes)) budget = 64'(shadow_cfg.max_result_bytes);

    if (r.scan_first) begin
      scan_halted = 1'b0;
      merge_sticky = 1'b0;
      held_reason = R_NONE;
      bytes_taken = '0;
      files_taken = '0;
      next_start = '0;
      live_seen = r.resumed && !r.collection_empty;
    end

    if (scan_halted) begin
      v = V_IGNORED;
    end else if (r.has_uncollected) begin
      v = V_BLOCKED;
      next_start = idx_next;
      scan_halted = 1'b1;
    end else begin
      if (!merge_sticky && r.file_capacity < shadow_cfg.small_file_size && !r.last_file) begin
        hit = R_SMALL;
      end else if (r.collection_empty &&
                   (r.alive_count != 0 || r.dead_count != 0 || r.deletion_count != 0)) begin
        hit = R_EMPTY;
      end else if (!live_seen && r.alive_count == 0 && r.deletion_count != 0) begin
        hit = R_ONLYDEL;
      end else if (r.dead_bytes >= shadow_cfg.dead_bytes_limit) begin
        hit = R_DEADBYTES;
      end else if (r.dead_bytes != 0 &&
                   (share_met(r.dead_bytes, 49'(r.dead_bytes) + 49'(r.alive_bytes),
                              shadow_cfg.dead_share_q16) ||
                    share_met(r.dead_bytes, 49'(r.file_capacity),
                              shadow_cfg.dead_share_q16))) begin
        hit = R_DEADSHARE;
      end else if (r.dead_count >= shadow_cfg.dead_count_limit) begin
        hit = R_DEADCOUNT;
      end
      if (hit != R_NONE) begin
        merge_sticky = 1'b1;
        held_reason = hit;
      end

      if (!merge_sticky) begin
        v = V_SKIP;
        if (r.alive_count != 0) live_seen = 1'b1;
      end else begin
        next_start = idx_next;
        bytes_after = 50'(bytes_taken) + 50'(r.file_capacity);
        if (held_reason != R_ONLYDEL && files_taken != 0 && 64'(bytes_after) >= budget &&
            (files_taken != 11'd1 || held_reason != R_SMALL)) begin
          v = V_STOP_BEFORE;
          scan_halted = 1'b1;
        end else begin
          bytes_taken = (bytes_after > 50'(BUDGET_MAX)) ? BUDGET_MAX : bytes_after[48:0];
          if (files_taken != COUNT_MAX) files_taken++;
          keep = live_seen && r.file_index != 0;
          if (64'(bytes_taken) >= budget ||
              (64'(bytes_taken) >= 64'(shadow_cfg.small_file_size) &&
               files_taken >= shadow_cfg.max_files)) begin
            v = V_SELECT_STOP;
            scan_halted = 1'b1;
          end else begin
            v = V_SELECT;
            if (r.alive_count != 0) live_seen = 1'b1;
          end
        end
      end
    end

    res.verdict = v;
    res.reason_code = held_reason;
    res.keep_deletions = keep;
    res.resume_index = (files_taken != 0) ? next_start : 17'd0;
    res.selected_total = files_taken;
    return res;
  endfunction

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      CFG_SMALL_FILE_SIZE:  shadow_cfg.small_file_size = val[31:0];
      CFG_DEAD_BYTES_LIMIT: shadow_cfg.dead_bytes_limit = val[47:0];
      CFG_DEAD_SHARE_Q16:   shadow_cfg.dead_share_q16 = val[16:0];
      CFG_DEAD_COUNT_LIMIT: shadow_cfg.dead_count_limit = val[31:0];
      CFG_MAX_FILES:        shadow_cfg.max_files = val[10:0];
      CFG_SIZE_FACTOR:      shadow_cfg.size_factor = val[7:0];
      CFG_JOURNAL_BYTES:    shadow_cfg.journal_bytes = val[31:0];
      default:              shadow_cfg.max_result_bytes = val[47:0];
    endcase
  endtask

  task automatic write_all_regs(input cfg_data_t vals [8]);
    for (int k = 0; k < 8; k++) write_reg(cfg_index_t'(k), vals[k]);
    config_sets++;
  endtask

  task automatic enqueue_record(input record_t rec);
    record_queue = {record_queue, rec};
  endtask

  task automatic wait_idle();
    while (record_queue.size() != 0 || record_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  function automatic record_t file_rec(bit first, bit last, logic [15:0] idx,
                                       logic [31:0] cap, logic [31:0] alive,
                                       logic [31:0] dead, logic [31:0] del,
                                       logic [47:0] dbytes, logic [47:0] abytes);
    record_t r;
    r = '0;
    r.scan_first = first;
    r.last_file = last;
    r.file_index = idx;
    r.file_capacity = cap;
    r.alive_count = alive;
    r.dead_count = dead;
    r.deletion_count = del;
    r.dead_bytes = dbytes;
    r.alive_bytes = abytes;
    return r;
  endfunction

  function automatic record_t random_record();
    record_t r;
    r.scan_first = ($urandom_range(0, 3) == 0);
    r.last_file = 1'($urandom_range(0, 1));
    r.file_index = 16'($urandom);
    r.collection_empty = ($urandom_range(0, 9) == 0);
    r.resumed = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: r.file_capacity = '0;
      1: r.file_capacity = shadow_cfg.small_file_size + $urandom_range(0, 64) - 32;
      default: r.file_capacity = 32'(rand_mag(32));
    endcase
    r.has_uncollected = ($urandom_range(0, 29) == 0);
    r.alive_count = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'(rand_mag(32));
    r.dead_count = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'(rand_mag(32));
    r.deletion_count = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'(rand_mag(32));
    r.dead_bytes = ($urandom_range(0, 3) == 0) ? 48'd0 : 48'(rand_mag(48));
    r.alive_bytes = 48'(rand_mag(48));
    return r;
  endfunction

  // Record driver: bursts of items with random gaps, fed from record_queue.
  always @(posedge clk) begin : sender
    record_t next_rec;
    result_t predicted;
    logic launch;
    if (rst) begin
      record_ch.valid <= 1'b0;
    end else if (!record_ch.valid || record_ch.ready) begin
      if (record_ch.valid) begin
        predicted = judge_record(record_ch.data);
        expected_results = {expected_results, predicted};
        records_sent++;
      end
      launch = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (record_queue.size() != 0) begin
        next_rec = record_queue.pop_front();
        launch = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      record_ch.valid <= launch;
      if (launch) record_ch.data <= next_rec;
    end
  end

  // Verdict monitor: checks each accepted item and stalls in changing patterns.
  always @(posedge clk) begin : receiver
    result_t want;
    result_t got;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (expected_results.size() == 0) begin
          note_mismatch("verdict arrived with no record pending");
        end else begin
          want = expected_results.pop_front();
          if (got.verdict !== want.verdict)
            note_mismatch($sformatf("verdict %0d, predicted %0d", got.verdict, want.verdict));
          if (got.reason_code !== want.reason_code)
            note_mismatch($sformatf("reason %0d, predicted %0d",
                                    got.reason_code, want.reason_code));
          if (got.keep_deletions !== want.keep_deletions)
            note_mismatch($sformatf("keep_deletions %0b, predicted %0b",
                                    got.keep_deletions, want.keep_deletions));
          if (got.resume_index !== want.resume_index)
            note_mismatch($sformatf("resume_index %0d, predicted %0d",
                                    got.resume_index, want.resume_index));
          if (got.selected_total !== want.selected_total)
            note_mismatch($sformatf("selected_total %0d, predicted %0d",
                                    got.selected_total, want.selected_total));
          verdict_seen[want.verdict]++;
        end
        results_checked++;
      end
      if (stall_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 2));
        stall_left = $urandom_range(8, 80);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        RX_OPEN:   result_ch.ready <= 1'b1;
        RX_RANDOM: result_ch.ready <= 1'($urandom_range(0, 1));
        default:   result_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : stimulus
    cfg_data_t reg_val [8];
    record_t r;
    int n;
    int start;
    int pushed;
    bit empty_scan;

    for (int k = 0; k < 8; k++) verdict_seen[k] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Default settings, and a scan that starts without a scan_first record.
    enqueue_record(file_rec(0, 0, 0, 1000, 5, 0, 0, 0, 0));
    enqueue_record(file_rec(0, 0, 1, 2000, 5, 0, 0, 0, 0));
    enqueue_record(file_rec(0, 0, 2, 3000, 5, 0, 0, 0, 0));
    enqueue_record(file_rec(0, 1, 3, 4000, 5, 0, 0, 0, 0));
    wait_idle();

    reg_val = '{48'd1000, 48'd1000000, 48'd32768, 48'd100, 48'd4, 48'd1, 48'd4194304,
                48'hFFFF_FFFF_FFFF};
    write_all_regs(reg_val);
    // Small file merged with an inherited reason, then a budget stop and an ignored file.
    r = file_rec(1, 0, 5, 500, 3, 0, 0, 0, 0);
    r.resumed = 1'b1;
    enqueue_record(r);
    enqueue_record(file_rec(0, 0, 6, 4000, 10, 0, 0, 0, 0));
    enqueue_record(file_rec(0, 0, 7, 32'h80_0000, 10, 0, 0, 0, 0));
    enqueue_record(file_rec(0, 0, 8, 500, 10, 0, 0, 0, 0));
    // Empty collection, then a file with uncollected entries.
    r = file_rec(1, 1, 0, 5000, 0, 1, 0, 0, 0);
    r.collection_empty = 1'b1;
    enqueue_record(r);
    r = file_rec(0, 0, 1, 5000, 2, 0, 0, 0, 0);
    r.has_uncollected = 1'b1;
    enqueue_record(r);
    // Only deletions, where the budget check does not apply.
    enqueue_record(file_rec(1, 0, 0, 5000, 0, 0, 7, 0, 0));
    enqueue_record(file_rec(0, 0, 1, 32'h90_0000, 0, 0, 3, 0, 0));
    // Dead bytes, dead share, zero capacity and dead count, one scan each.
    enqueue_record(file_rec(1, 0, 0, 5000, 1, 0, 0, 2000000, 0));
    enqueue_record(file_rec(1, 0, 0, 5000, 1, 0, 0, 600, 400));
    enqueue_record(file_rec(1, 0, 0, 0, 1, 0, 0, 1, 48'hFFFF_FFFF_FFFF));
    enqueue_record(file_rec(1, 0, 0, 5000, 1, 150, 0, 0, 0));
    // A skipped file marks live documents; the single small file is exempt from the budget.
    enqueue_record(file_rec(1, 0, 0, 5000, 10, 0, 0, 0, 0));
    enqueue_record(file_rec(0, 0, 1, 5000, 0, 0, 4, 0, 0));
    enqueue_record(file_rec(0, 0, 2, 500, 1, 0, 0, 0, 0));
    enqueue_record(file_rec(0, 0, 3, 32'h90_0000, 1, 0, 0, 0, 0));
    // All fields but has_uncollected at their maximum, then a scan_first record with all else zero.
    r = '1;
    r.has_uncollected = 1'b0;
    enqueue_record(r);
    enqueue_record(file_rec(1, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // One long scan of zero-size files is selected from start to end without a stop.
    reg_val = '{48'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd65536, 48'hFFFF_FFFF, 48'd1024, 48'd1,
                48'd16777216, 48'hFFFF_FFFF_FFFF};
    write_all_regs(reg_val);
    for (int i = 0; i < LONG_SCAN; i++) begin
      r = random_record();
      r.scan_first = (i == 0);
      r.last_file = (i == LONG_SCAN - 1);
      r.file_index = 16'(i);
      r.collection_empty = 1'b0;
      r.file_capacity = '0;
      r.has_uncollected = 1'b0;
      r.alive_count[0] = 1'b1;
      r.dead_count = '0;
      r.dead_bytes = '0;
      enqueue_record(r);
    end
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      for (int k = 0; k < 8; k++) begin
        case (cfg_index_t'(k))
          CFG_SMALL_FILE_SIZE:  reg_val[k] = 48'(rand_mag(26));
          CFG_DEAD_BYTES_LIMIT: reg_val[k] = 48'(rand_mag(44));
          CFG_DEAD_SHARE_Q16:   reg_val[k] = 48'($urandom_range(0, 65536));
          CFG_DEAD_COUNT_LIMIT: reg_val[k] = 48'(rand_mag(24));
          CFG_MAX_FILES:
            reg_val[k] = ($urandom_range(0, 9) == 0) ? 48'($urandom_range(1, 1024))
                                                     : 48'($urandom_range(1, 8));
          CFG_SIZE_FACTOR:      reg_val[k] = 48'($urandom_range(0, 8));
          CFG_JOURNAL_BYTES:    reg_val[k] = 48'(rand_mag(32));
          default:              reg_val[k] = 48'(rand_mag(48));
        endcase
        if (p == 0) reg_val[k] = reg_lo[k];
        else if (p == 1) reg_val[k] = reg_hi[k];
        else if (p > 2 && $urandom_range(0, 9) == 0)
          reg_val[k] = $urandom_range(0, 1) ? reg_hi[k] : reg_lo[k];
      end
      // A share above one is taken as written.
      if (p == 2) reg_val[CFG_DEAD_SHARE_Q16] = 48'h1FFFF;
      write_all_regs(reg_val);

      pushed = 0;
      while (pushed < PHASE_RECORDS) begin
        if ($urandom_range(0, 6) == 0) begin
          n = $urandom_range(1, 4);
          repeat (n) enqueue_record(random_record());
        end else begin
          n = $urandom_range(1, 10);
          start = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 65536 - n) : 0;
          empty_scan = ($urandom_range(0, 11) == 0);
          for (int i = 0; i < n; i++) begin
            r = random_record();
            r.scan_first = (i == 0);
            r.last_file = (i == n - 1);
            r.file_index = 16'(start + i);
            r.collection_empty = empty_scan;
            if (i == 0 && $urandom_range(0, 9) != 0) r.resumed = (start != 0);
            enqueue_record(r);
          end
        end
        pushed += n;
        // Halfway through one phase the stimulus holds off until every verdict is back.
        if (p == 3 && pushed >= PHASE_RECORDS / 2 && pushed - n < PHASE_RECORDS / 2)
          wait_idle();
      end
      wait_idle();
    end

    foreach (expected_results[i]) note_mismatch("predicted verdict never arrived");
    $display("Checked %0d verdicts for %0d records under %0d register settings.",
             results_checked, records_sent, config_sets);
    $display("Verdicts: skip %0d, select %0d, select-stop %0d, stop-before %0d, %s %0d, %s %0d.",
             verdict_seen[V_SKIP], verdict_seen[V_SELECT], verdict_seen[V_SELECT_STOP],
             verdict_seen[V_STOP_BEFORE], "blocked", verdict_seen[V_BLOCKED],
             "ignored", verdict_seen[V_IGNORED]);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/cvs_pkg.sv
rtl/cvs_stream_if.sv
rtl/cvs_budget.sv
rtl/cvs_rule_decode.sv
rtl/cvs_scan_state.sv
rtl/compaction_victim_selector.sv
tb/sv/compaction_victim_selector_tb.sv
